### rtl/core/imuof_pkg.sv
// Shared constants and register indexes for the IMU orientation filter.
package imuof_pkg;

  localparam int SAMPLE_W = 16;
  localparam int QUAT_W   = 32;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_SCALE    = 8'd3;

  localparam logic [CFG_W-1:0] PROP_GAIN_RST     = 32'd65536;
  localparam logic [CFG_W-1:0] INTEG_GAIN_RST    = 32'd0;
  localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RST = 32'd42949673;
  localparam logic [CFG_W-1:0] GYRO_SCALE_RST    = 32'd65536;

  // Saturation limits on the 66-bit working accumulator
  localparam logic signed [65:0] LIM32_S = 66'sd2147483647;
  localparam logic signed [65:0] LIM48_S = 66'sd140737488355327;

endpackage

### rtl/core/imu_orientation_filter.sv
// Mahony attitude filter (accelerometer and gyro) on one shared multiplier and root/divide unit.
// One request at a time: the next is taken the cycle after the result is loaded, and the
// load waits while the previous result is still held. Cost is set by the 32-step root and
// quotient loops of the shared subtractor (up to two roots and seven quotients) and by the
// shared 32x32 multiply.
// Synchronous reset: identity quaternion, zero integral, default registers, output empty.
module imu_orientation_filter
  import imuof_pkg::*;
#(
  parameter int FRAC_BITS = 30
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [SAMPLE_W-1:0]  accel_x,
  input  logic signed [SAMPLE_W-1:0]  accel_y,
  input  logic signed [SAMPLE_W-1:0]  accel_z,
  input  logic signed [SAMPLE_W-1:0]  gyro_x,
  input  logic signed [SAMPLE_W-1:0]  gyro_y,
  input  logic signed [SAMPLE_W-1:0]  gyro_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [QUAT_W-1:0]    quat_w,
  output logic signed [QUAT_W-1:0]    quat_x,
  output logic signed [QUAT_W-1:0]    quat_y,
  output logic signed [QUAT_W-1:0]    quat_z,
  output logic                        accel_applied,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_wdata
);

  localparam int F = FRAC_BITS;
  localparam int ITER = 32;
  localparam logic [4:0] CNT_LAST = 5'(ITER - 1);
  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [65:0] HALF_S = 66'sd1 <<< (FRAC_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_GYRO, S_SQ, S_ROOT, S_DSET, S_DIV, S_HV, S_HE,
    S_IT, S_PROP, S_H, S_NQ, S_NS, S_DONE
  } state_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic [47:0] mag48(input logic signed [47:0] v);
    return v[47] ? 48'(-v) : 48'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > LIM32_S) return 32'sh7FFF_FFFF;
    if (v < -LIM32_S) return 32'sh8000_0001;
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
    if (v > LIM48_S) return 48'sh7FFF_FFFF_FFFF;
    if (v < -LIM48_S) return 48'sh8000_0000_0001;
    return v[47:0];
  endfunction

  function automatic logic signed [31:0] pick_q(input logic [1:0] j,
                                                input logic signed [31:0] a0,
                                                input logic signed [31:0] a1,
                                                input logic signed [31:0] a2,
                                                input logic signed [31:0] a3);
    case (j)
      2'd0: return a0;
      2'd1: return a1;
      2'd2: return a2;
      default: return a3;
    endcase
  endfunction

  state_t state;
  logic [1:0] idx, k;
  logic ph;
  logic [4:0] cnt;
  logic npass, applied;

  logic [31:0] prop_gain, integ_gain, sample_period, gyro_scale;

  logic signed [15:0] accel [3];
  logic signed [15:0] gyro [3];
  logic signed [47:0] rate [3];
  logic signed [31:0] integ [3];
  logic signed [31:0] an [3];
  logic signed [31:0] hv [3];
  logic signed [31:0] he [3];
  logic signed [31:0] h [3];
  logic signed [31:0] nq [4];
  logic signed [31:0] q0, q1, q2, q3;

  logic [46:0] tmag;
  logic tneg;
  logic [63:0] prod;
  logic pneg;
  logic signed [65:0] acc;

  logic [33:0] rem;
  logic [31:0] root, quo;
  logic [63:0] rad;

  // multiplier operand select
  logic [1:0] sel_a, sel_b;
  logic sub_op;
  logic signed [31:0] sa, sb;
  logic [31:0] ma, mb;
  logic mneg;
  logic [47:0] rate_mag;

  always_comb begin
    sel_a = 2'd0;
    sel_b = 2'd0;
    sub_op = 1'b0;
    case (state)
      S_HV: begin
        case ({idx, k})
          4'b0000: begin sel_a = 2'd1; sel_b = 2'd3; end
          4'b0001: begin sel_a = 2'd0; sel_b = 2'd2; sub_op = 1'b1; end
          4'b0100: begin sel_a = 2'd0; sel_b = 2'd1; end
          4'b0101: begin sel_a = 2'd2; sel_b = 2'd3; end
          4'b1000: begin sel_a = 2'd0; sel_b = 2'd0; end
          4'b1001: begin sel_a = 2'd3; sel_b = 2'd3; end
          default: ;
        endcase
      end
      S_HE: begin
        case ({idx, k})
          4'b0000: begin sel_a = 2'd1; sel_b = 2'd2; end
          4'b0001: begin sel_a = 2'd2; sel_b = 2'd1; sub_op = 1'b1; end
          4'b0100: begin sel_a = 2'd2; sel_b = 2'd0; end
          4'b0101: begin sel_a = 2'd0; sel_b = 2'd2; sub_op = 1'b1; end
          4'b1000: begin sel_a = 2'd0; sel_b = 2'd1; end
          4'b1001: begin sel_a = 2'd1; sel_b = 2'd0; sub_op = 1'b1; end
          default: ;
        endcase
      end
      S_NQ: begin
        case ({idx, k})
          4'b0001: begin sel_a = 2'd1; sel_b = 2'd0; sub_op = 1'b1; end
          4'b0010: begin sel_a = 2'd2; sel_b = 2'd1; sub_op = 1'b1; end
          4'b0011: begin sel_a = 2'd3; sel_b = 2'd2; sub_op = 1'b1; end
          4'b0101: begin sel_a = 2'd0; sel_b = 2'd0; end
          4'b0110: begin sel_a = 2'd2; sel_b = 2'd2; end
          4'b0111: begin sel_a = 2'd3; sel_b = 2'd1; sub_op = 1'b1; end
          4'b1001: begin sel_a = 2'd0; sel_b = 2'd1; end
          4'b1010: begin sel_a = 2'd1; sel_b = 2'd2; sub_op = 1'b1; end
          4'b1011: begin sel_a = 2'd3; sel_b = 2'd0; end
          4'b1101: begin sel_a = 2'd0; sel_b = 2'd2; end
          4'b1110: begin sel_a = 2'd1; sel_b = 2'd1; end
          4'b1111: begin sel_a = 2'd2; sel_b = 2'd0; sub_op = 1'b1; end
          default: sel_a = idx;  // first term of each row: the old component itself
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    sa = '0;
    sb = '0;
    ma = '0;
    mb = '0;
    mneg = 1'b0;
    rate_mag = mag48(rate[idx]);
    case (state)
      S_GYRO: begin
        ma = {16'b0, mag16(gyro[idx])};
        mb = gyro_scale;
        mneg = gyro[idx][15];
      end
      S_SQ: begin
        ma = {16'b0, mag16(accel[idx])};
        mb = ma;
      end
      S_HV, S_HE, S_NQ: begin
        if (state == S_HV) begin
          sa = pick_q(sel_a, q0, q1, q2, q3);
          sb = pick_q(sel_b, q0, q1, q2, q3);
        end else if (state == S_HE) begin
          sa = an[sel_a];
          sb = hv[sel_b];
        end else begin
          sa = pick_q(sel_a, q0, q1, q2, q3);
          sb = (k == 2'd0) ? ONE_Q : h[sel_b];
        end
        ma = mag32(sa);
        mb = mag32(sb);
        mneg = sa[31] ^ sb[31];
      end
      S_IT: begin
        mb = sample_period;
        case (k)
          2'd0: begin
            ma = mag32(he[idx]);
            mb = integ_gain;
            mneg = he[idx][31];
          end
          2'd1: ma = {16'b0, tmag[15:0]};
          2'd2: ma = {1'b0, tmag[46:16]};
          default: ma = '0;
        endcase
      end
      S_PROP: begin
        ma = mag32(he[idx]);
        mb = prop_gain;
        mneg = he[idx][31];
      end
      S_H: begin
        ma = (k == 2'd0) ? {16'b0, rate_mag[15:0]} : rate_mag[47:16];
        mb = sample_period;
      end
      S_NS: begin
        ma = mag32(nq[idx]);
        mb = ma;
      end
      default: ;
    endcase
  end

  // accumulate path on the registered product
  logic signed [65:0] prod_s, prod_f, term_f, sh16, base, term, acc_next;

  always_comb begin
    prod_s = $signed({2'b00, prod});
    prod_f = prod_s >>> F;
    term_f = pneg ? -prod_f : prod_f;
    sh16 = prod_s >>> 16;
    base = (k == 2'd0) ? 66'sd0 : acc;
    term = '0;
    case (state)
      S_SQ, S_NS: begin
        base = (idx == 2'd0) ? 66'sd0 : acc;
        term = prod_s;
      end
      S_HV, S_HE, S_NQ: term = term_f;
      S_IT: begin
        base = (k == 2'd2) ? acc : 66'sd0;
        term = (k == 2'd1) ? sh16 : prod_s;
      end
      S_H: begin
        base = (k == 2'd1) ? acc : 66'sd0;
        term = (k == 2'd0) ? sh16 : prod_s;
      end
      default: ;
    endcase
    acc_next = sub_op ? base - term : base + term;
  end

  logic signed [65:0] gyro_m, inc_m, hm;
  logic signed [47:0] gyro_v, rate_int, rate_prop;
  logic signed [31:0] hv_val, integ_new, h_val;

  always_comb begin
    gyro_m = prod_s <<< (F - 16);
    gyro_v = sat48(pneg ? -gyro_m : gyro_m);
    hv_val = sat32((idx == 2'd2) ? acc_next - HALF_S : acc_next);
    inc_m = acc_next >>> 16;
    integ_new = sat32(66'(integ[idx]) + (tneg ? -inc_m : inc_m));
    rate_int = sat48(66'(rate[idx]) + 66'(integ[idx]));
    rate_prop = sat48(66'(rate[idx]) + (pneg ? -sh16 : sh16));
    hm = acc_next >>> 17;
    h_val = sat32(rate[idx][47] ? -hm : hm);
  end

  // shared subtractor for root and quotient steps
  logic [35:0] lhs, rhs;
  logic [36:0] diff;
  logic ge;
  logic [63:0] num;
  logic [31:0] qfinal, qmag;
  logic signed [31:0] an_val, qn_val;

  always_comb begin
    if (state == S_ROOT) begin
      lhs = {rem, rad[63:62]};
      rhs = {2'b0, root, 2'b01};
    end else begin
      lhs = {3'b0, rem[31:0], rad[63]};
      rhs = {4'b0, root};
    end
    diff = {1'b0, lhs} - {1'b0, rhs};
    ge = ~diff[36];
    num = npass ? (64'(mag32(nq[idx])) << F) : (64'(mag16(accel[idx])) << (F + 14));
    qfinal = {quo[30:0], ge};
    qmag = qfinal[31] ? 32'h7FFF_FFFF : qfinal;
    an_val = accel[idx][15] ? -$signed(qfinal) : $signed(qfinal);
    qn_val = nq[idx][31] ? -$signed(qmag) : $signed(qmag);
  end

  logic k_last, idx_last;

  always_comb begin
    if (state inside {S_HV, S_HE, S_H}) k_last = (k == 2'd1);
    else if (state inside {S_IT, S_NQ}) k_last = (k == 2'd3);
    else k_last = (k == 2'd0);
    if (state inside {S_NQ, S_NS}) idx_last = (idx == 2'd3);
    else if (state inside {S_DSET, S_DIV}) idx_last = npass ? (idx == 2'd3) : (idx == 2'd2);
    else idx_last = (idx == 2'd2);
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      k <= '0;
      ph <= 1'b0;
      cnt <= '0;
      npass <= 1'b0;
      applied <= 1'b0;
      out_valid <= 1'b0;
      prop_gain <= PROP_GAIN_RST;
      integ_gain <= INTEG_GAIN_RST;
      sample_period <= SAMPLE_PERIOD_RST;
      gyro_scale <= GYRO_SCALE_RST;
      q0 <= ONE_Q;
      q1 <= '0;
      q2 <= '0;
      q3 <= '0;
      for (int i = 0; i < 3; i++) integ[i] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROP_GAIN:     prop_gain <= cfg_wdata;
          CFG_INTEG_GAIN:    integ_gain <= cfg_wdata;
          CFG_SAMPLE_PERIOD: sample_period <= cfg_wdata;
          CFG_GYRO_SCALE:    gyro_scale <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            accel[0] <= accel_x;
            accel[1] <= accel_y;
            accel[2] <= accel_z;
            gyro[0] <= gyro_x;
            gyro[1] <= gyro_y;
            gyro[2] <= gyro_z;
            applied <= (accel_x != '0) || (accel_y != '0) || (accel_z != '0);
            idx <= '0;
            k <= '0;
            ph <= 1'b0;
            state <= S_GYRO;
          end
        end

        S_GYRO, S_SQ, S_HV, S_HE, S_IT, S_PROP, S_H, S_NQ, S_NS: begin
          if (!ph) begin
            prod <= 64'(ma) * 64'(mb);
            pneg <= mneg;
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            acc <= acc_next;
            case (state)
              S_GYRO: rate[idx] <= gyro_v;
              S_HV:   if (k_last) hv[idx] <= hv_val;
              S_HE:   if (k_last) he[idx] <= sat32(acc_next);
              S_IT: begin
                case (k)
                  2'd0: begin
                    tmag <= prod[62:16];
                    tneg <= pneg;
                  end
                  2'd2: integ[idx] <= integ_new;
                  2'd3: rate[idx] <= rate_int;
                  default: ;
                endcase
              end
              S_PROP: rate[idx] <= rate_prop;
              S_H:    if (k_last) h[idx] <= h_val;
              S_NQ:   if (k_last) nq[idx] <= sat32(acc_next);
              default: ;
            endcase
            if (!k_last) begin
              k <= k + 2'd1;
            end else begin
              k <= '0;
              if (!idx_last) begin
                idx <= idx + 2'd1;
              end else begin
                idx <= '0;
                case (state)
                  S_GYRO: state <= applied ? S_SQ : S_H;
                  S_SQ: begin
                    rad <= {4'b0, acc_next[31:0], 28'b0};
                    rem <= '0;
                    root <= '0;
                    cnt <= '0;
                    npass <= 1'b0;
                    state <= S_ROOT;
                  end
                  S_HV: state <= S_HE;
                  S_HE: begin
                    if (integ_gain != '0) begin
                      state <= S_IT;
                    end else begin
                      for (int i = 0; i < 3; i++) integ[i] <= '0;
                      state <= S_PROP;
                    end
                  end
                  S_IT:   state <= S_PROP;
                  S_PROP: state <= S_H;
                  S_H:    state <= S_NQ;
                  S_NQ:   state <= S_NS;
                  S_NS: begin
                    if (acc_next[63:0] == '0) begin
                      // degenerate quaternion: fall back to identity
                      q0 <= ONE_Q;
                      q1 <= '0;
                      q2 <= '0;
                      q3 <= '0;
                      state <= S_DONE;
                    end else begin
                      rad <= acc_next[63:0];
                      rem <= '0;
                      root <= '0;
                      cnt <= '0;
                      npass <= 1'b1;
                      state <= S_ROOT;
                    end
                  end
                  default: state <= S_IDLE;
                endcase
              end
            end
          end
        end

        S_ROOT: begin
          rem <= ge ? diff[33:0] : lhs[33:0];
          root <= {root[30:0], ge};
          rad <= {rad[61:0], 2'b00};
          cnt <= cnt + 5'd1;
          if (cnt == CNT_LAST) begin
            idx <= '0;
            state <= S_DSET;
          end
        end

        S_DSET: begin
          rem <= {2'b00, num[63:32]};
          rad <= {num[31:0], 32'b0};
          cnt <= '0;
          state <= S_DIV;
        end

        S_DIV: begin
          rem <= ge ? {2'b00, diff[31:0]} : {2'b00, lhs[31:0]};
          rad <= {rad[62:0], 1'b0};
          quo <= qfinal;
          cnt <= cnt + 5'd1;
          if (cnt == CNT_LAST) begin
            if (!npass) begin
              an[idx] <= an_val;
            end else begin
              case (idx)
                2'd0: q0 <= qn_val;
                2'd1: q1 <= qn_val;
                2'd2: q2 <= qn_val;
                default: q3 <= qn_val;
              endcase
            end
            if (idx_last) begin
              idx <= '0;
              k <= '0;
              ph <= 1'b0;
              state <= npass ? S_DONE : S_HV;
            end else begin
              idx <= idx + 2'd1;
              state <= S_DSET;
            end
          end
        end

        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            quat_w <= q0;
            quat_x <= q1;
            quat_y <= q2;
            quat_z <= q3;
            accel_applied <= applied;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/imuof_chk.sv
// Port-level checks for the IMU orientation filter, bound to the top level.
module imuof_chk
  import imuof_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [QUAT_W-1:0] quat_w,
  input logic                     accel_applied
);

  // a taken request keeps the block busy
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after a request was taken");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(quat_w) && $stable(accel_applied)))
    else $error("stalled result changed or dropped");

  a_reset_state: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("block not idle and empty after reset");

  // a new result appears only as the block returns to idle
  a_result_on_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (in_ready && !$past(in_ready)))
    else $error("result loaded outside the end of a request");

endmodule

bind imu_orientation_filter imuof_chk u_imuof_chk (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .quat_w(quat_w),
  .accel_applied(accel_applied)
);

### dv/tb_imu_orientation_filter.sv
// Self-checking testbench for the IMU orientation filter: directed table, then random samples.
module tb_imu_orientation_filter;
  import imuof_pkg::*;

  localparam int FRAC = 30;
  localparam longint ONE_Q = 64'sd1 << FRAC;
  localparam longint HALF_Q = 64'sd1 << (FRAC - 1);
  localparam longint LIM32 = 64'sd2147483647;
  localparam longint LIM48 = (64'sd1 << 47) - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNMAPPED = 8'd9;
  localparam int HOLD_CYCLES = 3000;
  localparam int DRAIN_CYCLES = 450;

  typedef struct {
    logic signed [SAMPLE_W-1:0] ax, ay, az, gx, gy, gz;
  } sample_t;

  typedef struct {
    logic signed [QUAT_W-1:0] w, x, y, z;
    logic applied;
  } attitude_t;

  typedef struct {
    sample_t s;
    bit      typed;
    attitude_t exp;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [SAMPLE_W-1:0] accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z;
  logic signed [QUAT_W-1:0] quat_w, quat_x, quat_y, quat_z;
  logic accel_applied;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  imu_orientation_filter i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .gyro_x(gyro_x), .gyro_y(gyro_y), .gyro_z(gyro_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .accel_applied(accel_applied),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Filter model state
  int unsigned m_prop, m_integ, m_period, m_scale;
  longint m_quat[4];
  longint m_integral[3];

  attitude_t attitude_q[$];
  int err_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int applied_seen = 0;
  int settings_used = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint unsigned magn(longint v);
    longint unsigned u;
    u = v;
    return (v < 0) ? -u : u;
  endfunction

  function automatic longint signed_of(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint fmul(longint a, longint b, int sh);
    longint unsigned m;
    m = (magn(a) * magn(b)) >> sh;
    return signed_of(m, (a < 0) != (b < 0));
  endfunction

  function automatic longint fmul_wide(longint a, int unsigned d, int sh);
    longint unsigned ma, hi, lo, dd, m;
    ma = magn(a);
    hi = ma >> 16;
    lo = ma & 64'hFFFF;
    dd = 64'(d);
    m = (hi * dd + ((lo * dd) >> 16)) >> (sh - 16);
    return signed_of(m, a < 0);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic model_reset();
    m_prop = PROP_GAIN_RST;
    m_integ = INTEG_GAIN_RST;
    m_period = SAMPLE_PERIOD_RST;
    m_scale = GYRO_SCALE_RST;
    m_quat[0] = ONE_Q;
    for (int i = 1; i < 4; i++) m_quat[i] = 0;
    for (int i = 0; i < 3; i++) m_integral[i] = 0;
  endtask

  function automatic attitude_t update_attitude(sample_t s);
    longint a[3], g[3], rate[3], h[3], q[4], nq[4], an[3], hv[3], he[3];
    longint t, inc;
    longint unsigned ss, r;
    bit app;
    attitude_t res;
    a[0] = longint'(s.ax); a[1] = longint'(s.ay); a[2] = longint'(s.az);
    g[0] = longint'(s.gx); g[1] = longint'(s.gy); g[2] = longint'(s.gz);
    for (int i = 0; i < 3; i++)
      rate[i] = clip(g[i] * longint'(m_scale) * (64'sd1 << (FRAC - 16)), LIM48);
    for (int i = 0; i < 4; i++) q[i] = m_quat[i];
    app = (a[0] != 0) || (a[1] != 0) || (a[2] != 0);
    if (app) begin
      ss = magn(a[0]) * magn(a[0]) + magn(a[1]) * magn(a[1]) + magn(a[2]) * magn(a[2]);
      r = int_sqrt(ss << 28);
      for (int i = 0; i < 3; i++) an[i] = signed_of((magn(a[i]) << (FRAC + 14)) / r, a[i] < 0);
      hv[0] = clip(fmul(q[1], q[3], FRAC) - fmul(q[0], q[2], FRAC), LIM32);
      hv[1] = clip(fmul(q[0], q[1], FRAC) + fmul(q[2], q[3], FRAC), LIM32);
      hv[2] = clip(fmul(q[0], q[0], FRAC) - HALF_Q + fmul(q[3], q[3], FRAC), LIM32);
      he[0] = clip(fmul(an[1], hv[2], FRAC) - fmul(an[2], hv[1], FRAC), LIM32);
      he[1] = clip(fmul(an[2], hv[0], FRAC) - fmul(an[0], hv[2], FRAC), LIM32);
      he[2] = clip(fmul(an[0], hv[1], FRAC) - fmul(an[1], hv[0], FRAC), LIM32);
      for (int i = 0; i < 3; i++) begin
        if (m_integ != 0) begin
          t = fmul(he[i], longint'(m_integ), 16);
          inc = fmul_wide(t, m_period, 32);
          m_integral[i] = clip(m_integral[i] + inc, LIM32);
          rate[i] = clip(rate[i] + m_integral[i], LIM48);
        end else begin
          m_integral[i] = 0;
        end
        rate[i] = clip(rate[i] + fmul(he[i], longint'(m_prop), 16), LIM48);
      end
    end
    for (int i = 0; i < 3; i++) h[i] = clip(fmul_wide(rate[i], m_period, 33), LIM32);
    nq[0] = q[0] - fmul(q[1], h[0], FRAC) - fmul(q[2], h[1], FRAC) - fmul(q[3], h[2], FRAC);
    nq[1] = q[1] + fmul(q[0], h[0], FRAC) + fmul(q[2], h[2], FRAC) - fmul(q[3], h[1], FRAC);
    nq[2] = q[2] + fmul(q[0], h[1], FRAC) - fmul(q[1], h[2], FRAC) + fmul(q[3], h[0], FRAC);
    nq[3] = q[3] + fmul(q[0], h[2], FRAC) + fmul(q[1], h[1], FRAC) - fmul(q[2], h[0], FRAC);
    ss = 0;
    for (int i = 0; i < 4; i++) begin
      nq[i] = clip(nq[i], LIM32);
      ss = ss + magn(nq[i]) * magn(nq[i]);
    end
    if (ss == 0) begin
      // degenerate quaternion: fall back to identity
      m_quat[0] = ONE_Q;
      for (int i = 1; i < 4; i++) m_quat[i] = 0;
    end else begin
      r = int_sqrt(ss);
      for (int i = 0; i < 4; i++)
        m_quat[i] = clip(signed_of((magn(nq[i]) << FRAC) / r, nq[i] < 0), LIM32);
    end
    res.w = m_quat[0][31:0];
    res.x = m_quat[1][31:0];
    res.y = m_quat[2][31:0];
    res.z = m_quat[3][31:0];
    res.applied = app;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (attitude_q.size() == 0) begin
        report_mismatch("unexpected result, none pending", longint'(quat_w), 64'sd0);
      end else begin
        attitude_t e;
        e = attitude_q.pop_front();
        if (quat_w !== e.w) report_mismatch("quat_w", longint'(quat_w), longint'(e.w));
        if (quat_x !== e.x) report_mismatch("quat_x", longint'(quat_x), longint'(e.x));
        if (quat_y !== e.y) report_mismatch("quat_y", longint'(quat_y), longint'(e.y));
        if (quat_z !== e.z) report_mismatch("quat_z", longint'(quat_z), longint'(e.z));
        if (accel_applied !== e.applied)
          report_mismatch("accel_applied", longint'(accel_applied), longint'(e.applied));
        if (e.applied) applied_seen++;
      end
    end
  end

  // Receiver: random back-pressure (always ready while calm), one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
      end
    end
  end

  task automatic send_request(sample_t s, bit typed, attitude_t exp);
    attitude_t pred;
    while (!calm && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    accel_x <= s.ax; accel_y <= s.ay; accel_z <= s.az;
    gyro_x <= s.gx; gyro_y <= s.gy; gyro_z <= s.gz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = update_attitude(s);
    attitude_q.push_back(typed ? exp : pred);
    items_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_PROP_GAIN:     m_prop = val;
      CFG_INTEG_GAIN:    m_integ = val;
      CFG_SAMPLE_PERIOD: m_period = val;
      CFG_GYRO_SCALE:    m_scale = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (attitude_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic apply_setting(int unsigned p, int unsigned ig, int unsigned per,
                               int unsigned sc);
    wait_idle();
    write_reg(CFG_PROP_GAIN, p);
    write_reg(CFG_INTEG_GAIN, ig);
    write_reg(CFG_SAMPLE_PERIOD, per);
    write_reg(CFG_GYRO_SCALE, sc);
    settings_used++;
  endtask

  function automatic sample_t sample_of(int ax, int ay, int az, int gx, int gy, int gz);
    sample_t s;
    s.ax = SAMPLE_W'(ax); s.ay = SAMPLE_W'(ay); s.az = SAMPLE_W'(az);
    s.gx = SAMPLE_W'(gx); s.gy = SAMPLE_W'(gy); s.gz = SAMPLE_W'(gz);
    return s;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] near(int span);
    return SAMPLE_W'(int'($urandom_range(2 * span)) - span);
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int kind;
    kind = $urandom_range(99);
    if (kind < 60) begin
      // plausible motion: gravity-sized accel, modest rates
      s.ax = near(6000); s.ay = near(6000); s.az = SAMPLE_W'(16384 + int'(near(4000)));
      s.gx = near(300); s.gy = near(300); s.gz = near(300);
    end else if (kind < 75) begin
      s.ax = '0; s.ay = '0; s.az = '0;
      s.gx = near(2000); s.gy = near(2000); s.gz = near(2000);
    end else begin
      s.ax = SAMPLE_W'($urandom); s.ay = SAMPLE_W'($urandom); s.az = SAMPLE_W'($urandom);
      s.gx = SAMPLE_W'($urandom); s.gy = SAMPLE_W'($urandom); s.gz = SAMPLE_W'($urandom);
    end
    return s;
  endfunction

  row_t stim_table[$];

  task automatic add_row(sample_t s, bit typed, attitude_t exp);
    row_t r;
    r.s = s;
    r.typed = typed;
    r.exp = exp;
    stim_table.push_back(r);
  endtask

  initial begin
    attitude_t ident0, ident1, none;
    rst <= 1'b1;
    in_valid <= 1'b0;
    accel_x <= '0; accel_y <= '0; accel_z <= '0;
    gyro_x <= '0; gyro_y <= '0; gyro_z <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    model_reset();
    ident0.w = 32'sd1073741824; ident0.x = '0; ident0.y = '0; ident0.z = '0;
    ident0.applied = 1'b0;
    ident1 = ident0;
    ident1.applied = 1'b1;
    none = ident0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // At rest from reset the attitude stays at identity; later rows are checked against the model
    add_row(sample_of(0, 0, 0, 0, 0, 0), 1'b1, ident0);
    add_row(sample_of(0, 0, 1, 0, 0, 0), 1'b1, ident1);
    add_row(sample_of(0, 0, 16384, 0, 0, 0), 1'b1, ident1);
    add_row(sample_of(32767, 32767, 32767, 32767, 32767, 32767), 1'b0, none);
    add_row(sample_of(-32768, -32768, -32768, -32768, -32768, -32768), 1'b0, none);
    add_row(sample_of(32767, -32768, 0, -32768, 32767, 0), 1'b0, none);
    add_row(sample_of(0, 0, 0, 32767, 0, 0), 1'b0, none);
    add_row(sample_of(0, 0, 0, -32768, -32768, -32768), 1'b0, none);
    add_row(sample_of(-1, -1, -1, 1, -1, 1), 1'b0, none);
    add_row(sample_of(1, 0, 0, 0, 0, 0), 1'b0, none);
    add_row(sample_of(0, -1, 0, 0, 0, 5), 1'b0, none);
    foreach (stim_table[i]) send_request(stim_table[i].s, stim_table[i].typed, stim_table[i].exp);

    // Saturated gains, period and scale; unmapped index must be ignored
    apply_setting(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    write_reg(CFG_IDX_UNMAPPED, 32'h12345678);
    add_row(sample_of(32767, 0, 0, 32767, -32768, 1), 1'b0, none);
    add_row(sample_of(0, 0, 0, -32768, 32767, -1), 1'b0, none);
    add_row(sample_of(-32768, 32767, 1, 0, 0, 0), 1'b0, none);
    for (int i = stim_table.size() - 3; i < stim_table.size(); i++)
      send_request(stim_table[i].s, 1'b0, none);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apply_setting(32'd65536, 32'd6554, 32'd42949673, 32'd1144);
        1: apply_setting(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        2: apply_setting(32'd0, 32'd0, 32'd1, 32'd0);
        3: apply_setting($urandom, $urandom, $urandom_range(32'hFFFFFFFF, 1), $urandom);
        4: apply_setting(32'd131072, 32'd655, 32'd4294967, 32'd70);
        default: apply_setting(PROP_GAIN_RST, 32'd65536, SAMPLE_PERIOD_RST, GYRO_SCALE_RST);
      endcase
      if (ph == 0) hold_req = 1'b1;
      calm = (ph == 4);
      for (int n = 0; n < 80; n++) send_request(random_sample(), 1'b0, none);
    end
    calm = 1'b0;

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d samples over %0d register settings, %0d results (%0d corrected)",
             items_sent, settings_used, results_seen, applied_seen);
    $display("mismatches counted: %0d, long output hold-off exercised: %0d",
             err_count, hold_done);
    if (err_count == 0 && attitude_q.size() == 0) begin
      $display("tb_imu_orientation_filter passed");
    end else begin
      $display("tb_imu_orientation_filter failed");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("tb_imu_orientation_filter failed");
    $finish;
  end

endmodule
